>>> sv/mep_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time pixel core.
// Used by the channel interfaces, the multiplier unit and the top level.
// No dependencies.
package mep_pkg;

  localparam int unsigned CoordBitsDefault = 12;
  localparam int unsigned FracBitsDefault  = 26;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned ProdWidth  = 64;
  localparam int unsigned StepWidth  = 31;
  localparam int unsigned LimitWidth = 16;
  localparam int unsigned PixelWidth = 8;
  localparam int unsigned CfgIdxWidth = 3;

  // Configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_ORIGIN_REAL = 3'd0,
    CFG_ORIGIN_IMAG = 3'd1,
    CFG_STEP_REAL   = 3'd2,
    CFG_STEP_IMAG   = 3'd3,
    CFG_ITER_LIMIT  = 3'd4
  } cfg_idx_e;

  localparam logic signed [DataWidth-1:0] OriginRealReset = -32'sd134217728;
  localparam logic signed [DataWidth-1:0] OriginImagReset = 32'sd67108864;
  localparam logic [StepWidth-1:0]        StepRealReset   = 31'd314573;
  localparam logic [StepWidth-1:0]        StepImagReset   = 31'd279621;
  localparam logic [LimitWidth-1:0]       IterLimitReset  = 16'd1500;

  localparam logic [PixelWidth-1:0] PixelBounded = 8'd255;
  localparam logic [PixelWidth-1:0] PixelEscaped = 8'd0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CRE,
    S_CIM,
    S_CIM2,
    S_TEST,
    S_MXX,
    S_MYY,
    S_MXY
  } state_e;

  // Wide signed sum, clamped to the signed 32-bit range
  typedef logic signed [65:0] wide_t;

  function automatic logic signed [DataWidth-1:0] sat32(input wide_t v);
    logic signed [DataWidth-1:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DataWidth-1:0];
    end
    return r;
  endfunction

  function automatic wide_t ext32(input logic signed [DataWidth-1:0] v);
    return {{34{v[DataWidth-1]}}, v};
  endfunction

  function automatic wide_t ext64(input logic signed [ProdWidth-1:0] v);
    return {{2{v[ProdWidth-1]}}, v};
  endfunction

endpackage

>>> sv/mep_if.sv
// Valid/ready channel interfaces of the Mandelbrot escape-time pixel core:
// pixel request, pixel result and configuration write.
// Depends on mep_pkg.
interface mep_in_if #(
  parameter int unsigned COORD_BITS = mep_pkg::CoordBitsDefault
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface mep_out_if;
  logic                               valid;
  logic                               ready;
  logic [mep_pkg::PixelWidth-1:0]     pixel_value;
  logic [mep_pkg::LimitWidth-1:0]     iteration_count;

  modport source (output valid, pixel_value, iteration_count, input ready);
  modport sink   (input valid, pixel_value, iteration_count, output ready);
endinterface

interface mep_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mep_pkg::CfgIdxWidth-1:0]   index;
  logic [mep_pkg::DataWidth-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/mep_mul.sv
// Shared signed 32x32 multiplier with registered 64-bit product.
// Depends on mep_pkg.
module mep_mul (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [mep_pkg::DataWidth-1:0]   a_i,
  input  logic signed [mep_pkg::DataWidth-1:0]   b_i,
  output logic signed [mep_pkg::ProdWidth-1:0]   p_o
);

  logic signed [mep_pkg::ProdWidth-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

>>> sv/mandelbrot_escape_pixel_core.sv
// Mandelbrot escape-time pixel core: top level with sequencer and datapath.
// Depends on mep_pkg, mep_if (channel interfaces) and mep_mul.
//
// One pixel request at a time. After a request is taken, the sequencer forms the
// point c, then each iteration of z = z*z + c runs on the single shared 32x32
// multiplier: the escape test issues x*x, then y*y, then x*y, then the update of
// z and the counter. A finished pixel waits in the escape test until the previous
// result has left. The result sits in an output register, so the next request is
// taken as soon as the sequencer is back to idle even while the previous result
// waits. Configuration writes are taken in every cycle.
module mandelbrot_escape_pixel_core #(
  parameter int unsigned COORD_BITS = mep_pkg::CoordBitsDefault,
  parameter int unsigned FRAC_BITS  = mep_pkg::FracBitsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  mep_in_if.sink    in_i,
  mep_out_if.source out_o,
  mep_cfg_if.sink   cfg_i
);

  localparam int unsigned DW = mep_pkg::DataWidth;
  localparam int unsigned PW = mep_pkg::ProdWidth;
  localparam int unsigned LW = mep_pkg::LimitWidth;
  localparam logic [DW:0] Bound = (DW+1)'(4) << FRAC_BITS;

  // Configuration registers
  logic signed [DW-1:0]             org_re_q, org_im_q;
  logic [mep_pkg::StepWidth-1:0]    step_re_q, step_im_q;
  logic [LW-1:0]                    limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_re_q  <= mep_pkg::OriginRealReset;
      org_im_q  <= mep_pkg::OriginImagReset;
      step_re_q <= mep_pkg::StepRealReset;
      step_im_q <= mep_pkg::StepImagReset;
      limit_q   <= mep_pkg::IterLimitReset;
    end else if (cfg_i.valid) begin
      unique case (mep_pkg::cfg_idx_e'(cfg_i.index))
        mep_pkg::CFG_ORIGIN_REAL: org_re_q  <= cfg_i.data;
        mep_pkg::CFG_ORIGIN_IMAG: org_im_q  <= cfg_i.data;
        mep_pkg::CFG_STEP_REAL:   step_re_q <= cfg_i.data[mep_pkg::StepWidth-1:0];
        mep_pkg::CFG_STEP_IMAG:   step_im_q <= cfg_i.data[mep_pkg::StepWidth-1:0];
        mep_pkg::CFG_ITER_LIMIT:  limit_q   <= cfg_i.data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  // Sequencer and datapath registers
  mep_pkg::state_e state_q, state_d;
  logic                       out_valid_q, out_valid_d;
  logic [mep_pkg::PixelWidth-1:0] pix_q, pix_d;
  logic [LW-1:0]              cnt_out_q, cnt_out_d;
  logic [LW-1:0]              cnt_q, cnt_d;
  logic [COORD_BITS-1:0]      col_q, col_d, row_q, row_d;
  logic signed [DW-1:0]       c_re_q, c_re_d, c_im_q, c_im_d;
  logic signed [DW-1:0]       x_q, x_d, y_q, y_d, xs_q, xs_d, ys_q, ys_d;

  logic                       mul_en;
  logic signed [DW-1:0]       mul_a, mul_b;
  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       sq_sh, xy_sh;
  logic [DW:0]                esc_sum;
  logic                       keep_going;
  logic                       out_free;

  mep_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign sq_sh      = prod >>> FRAC_BITS;
  assign xy_sh      = prod >>> (FRAC_BITS - 1);
  assign esc_sum    = {1'b0, xs_q} + {1'b0, ys_q};
  assign keep_going = (cnt_q < limit_q) && (esc_sum < Bound);
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_o.ready;
    pix_d       = pix_q;
    cnt_out_d   = cnt_out_q;
    cnt_d       = cnt_q;
    col_d       = col_q;
    row_d       = row_q;
    c_re_d      = c_re_q;
    c_im_d      = c_im_q;
    x_d         = x_q;
    y_d         = y_q;
    xs_d        = xs_q;
    ys_d        = ys_q;
    mul_en      = 1'b0;
    mul_a       = x_q;
    mul_b       = x_q;

    unique case (state_q)
      mep_pkg::S_IDLE: begin
        if (in_i.valid) begin
          col_d   = in_i.column;
          row_d   = in_i.row;
          x_d     = '0;
          y_d     = '0;
          xs_d    = '0;
          ys_d    = '0;
          cnt_d   = LW'(1);
          state_d = mep_pkg::S_CRE;
        end
      end
      mep_pkg::S_CRE: begin
        mul_en  = 1'b1;
        mul_a   = DW'(col_q);
        mul_b   = {1'b0, step_re_q};
        state_d = mep_pkg::S_CIM;
      end
      mep_pkg::S_CIM: begin
        c_re_d  = mep_pkg::sat32(mep_pkg::ext32(org_re_q) + mep_pkg::ext64(prod));
        mul_en  = 1'b1;
        mul_a   = DW'(row_q);
        mul_b   = {1'b0, step_im_q};
        state_d = mep_pkg::S_CIM2;
      end
      mep_pkg::S_CIM2: begin
        c_im_d  = mep_pkg::sat32(mep_pkg::ext32(org_im_q) - mep_pkg::ext64(prod));
        state_d = mep_pkg::S_TEST;
      end
      mep_pkg::S_TEST: begin
        if (keep_going) begin
          // start the next step by squaring x on the shared multiplier
          mul_en  = 1'b1;
          mul_a   = x_q;
          mul_b   = x_q;
          state_d = mep_pkg::S_MXX;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          pix_d       = (cnt_q >= limit_q) ? mep_pkg::PixelBounded : mep_pkg::PixelEscaped;
          cnt_out_d   = cnt_q;
          state_d     = mep_pkg::S_IDLE;
        end
      end
      mep_pkg::S_MXX: begin
        xs_d    = mep_pkg::sat32(mep_pkg::ext64(sq_sh));
        mul_en  = 1'b1;
        mul_a   = y_q;
        mul_b   = y_q;
        state_d = mep_pkg::S_MYY;
      end
      mep_pkg::S_MYY: begin
        ys_d    = mep_pkg::sat32(mep_pkg::ext64(sq_sh));
        mul_en  = 1'b1;
        mul_a   = x_q;
        mul_b   = y_q;
        state_d = mep_pkg::S_MXY;
      end
      mep_pkg::S_MXY: begin
        // old x and y are consumed; advance z and the counter
        y_d     = mep_pkg::sat32(mep_pkg::ext32(mep_pkg::sat32(mep_pkg::ext64(xy_sh)))
                                 + mep_pkg::ext32(c_im_q));
        x_d     = mep_pkg::sat32(mep_pkg::ext32(xs_q) - mep_pkg::ext32(ys_q)
                                 + mep_pkg::ext32(c_re_q));
        cnt_d   = cnt_q + LW'(1);
        state_d = mep_pkg::S_TEST;
      end
      default: state_d = mep_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mep_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= LW'(1);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q     <= pix_d;
    cnt_out_q <= cnt_out_d;
    col_q     <= col_d;
    row_q     <= row_d;
    c_re_q    <= c_re_d;
    c_im_q    <= c_im_d;
    x_q       <= x_d;
    y_q       <= y_d;
    xs_q      <= xs_d;
    ys_q      <= ys_d;
  end

  assign in_i.ready            = (state_q == mep_pkg::S_IDLE);
  assign out_o.valid           = out_valid_q;
  assign out_o.pixel_value     = pix_q;
  assign out_o.iteration_count = cnt_out_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == mep_pkg::S_CRE)
    else $error("request accepted but sequencer did not start");

  a_iter_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mep_pkg::S_MXY |=>
      state_q == mep_pkg::S_TEST && cnt_q == $past(cnt_q) + LW'(1))
    else $error("iteration update did not advance counter");

  a_result_from_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == mep_pkg::S_TEST)
    else $error("result loaded outside the escape test");
`endif

endmodule

>>> bench/tb_top.sv
// Self-checking bench for mandelbrot_escape_pixel_core: sends pixel requests and
// register writes, predicts escape counts in Q6.26 and checks every result.
// Depends on mep_pkg and the channel interfaces in mep_if.
module tb_top;

  localparam int unsigned COORD_BITS = mep_pkg::CoordBitsDefault;
  localparam int unsigned FRAC_BITS  = mep_pkg::FracBitsDefault;
  localparam int unsigned CfgIdxW    = mep_pkg::CfgIdxWidth;
  localparam int unsigned DataW      = mep_pkg::DataWidth;
  localparam int unsigned StepW      = mep_pkg::StepWidth;
  localparam int unsigned LimitW     = mep_pkg::LimitWidth;
  localparam int unsigned PixelW     = mep_pkg::PixelWidth;
  localparam int          WatchdogLimit = 1000000;
  localparam int          TailCycles    = 40;
  localparam int          HoldCycles    = 400;
  localparam int          MaxReports    = 10;
  localparam int          RandomPhases  = 8;
  localparam int          PhaseItems    = 50;
  localparam longint      SatHi = 64'sd2147483647;
  localparam longint      SatLo = -64'sd2147483648;
  localparam logic [CfgIdxW-1:0] CfgIdxFirstUnused = CfgIdxW'(mep_pkg::CFG_ITER_LIMIT + 1);

  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } pixel_req_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_value;
    logic [LimitW-1:0] iteration_count;
  } pixel_res_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [DataW-1:0]   data;
  } cfg_write_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  mep_in_if #(.COORD_BITS(COORD_BITS)) pix_if ();
  mep_out_if res_if ();
  mep_cfg_if cfg_if ();

  mandelbrot_escape_pixel_core #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (pix_if.sink),
    .out_o (res_if.source),
    .cfg_i (cfg_if.sink)
  );

  pixel_req_t pixel_req_q[$];
  cfg_write_t cfg_write_q[$];
  pixel_res_t expected_px_q[$];

  // Register copy used for prediction
  logic signed [DataW-1:0] m_origin_re;
  logic signed [DataW-1:0] m_origin_im;
  logic [StepW-1:0]        m_step_re;
  logic [StepW-1:0]        m_step_im;
  logic [LimitW-1:0]       m_limit;

  int   send_idle_pct;
  int   recv_stall_pct;
  logic rx_hold;
  int   mismatches = 0;
  int   quiet_cycles;

  function automatic longint clamp32(input longint v);
    if (v > SatHi) return SatHi;
    if (v < SatLo) return SatLo;
    return v;
  endfunction

  function automatic pixel_res_t predict_escape(input logic [COORD_BITS-1:0] col,
                                                input logic [COORD_BITS-1:0] row);
    longint      c_re, c_im, x, y, xsq, ysq, xy, bound;
    int unsigned n;
    pixel_res_t  r;
    c_re  = clamp32(longint'(m_origin_re) + longint'(col) * longint'(m_step_re));
    c_im  = clamp32(longint'(m_origin_im) - longint'(row) * longint'(m_step_im));
    bound = longint'(4) <<< FRAC_BITS;
    x     = 0;
    y     = 0;
    xsq   = 0;
    ysq   = 0;
    n     = 1;
    // escape test looks at the squares of the previous step
    while (n < m_limit && xsq + ysq < bound) begin
      xy  = x * y;
      xsq = clamp32(x * x >>> FRAC_BITS);
      ysq = clamp32(y * y >>> FRAC_BITS);
      y   = clamp32(clamp32(xy >>> (FRAC_BITS - 1)) + c_im);
      x   = clamp32(xsq - ysq + c_re);
      n++;
    end
    r.pixel_value     = (n >= m_limit) ? mep_pkg::PixelBounded : mep_pkg::PixelEscaped;
    r.iteration_count = LimitW'(n);
    return r;
  endfunction

  task automatic note_failure(input string what);
    if (mismatches < MaxReports) $display("%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic post_pixel(input int col, input int row);
    pixel_req_t p;
    p.column = COORD_BITS'(col);
    p.row    = COORD_BITS'(row);
    pixel_req_q.push_back(p);
  endtask

  task automatic post_cfg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] d);
    cfg_write_t w;
    w.index = idx;
    w.data  = d;
    cfg_write_q.push_back(w);
  endtask

  task automatic wait_drained();
    while (pixel_req_q.size() != 0 || pix_if.valid || cfg_write_q.size() != 0 ||
           cfg_if.valid || expected_px_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write all five registers while idle; fill unused upper bits with junk
  task automatic load_view(input logic signed [DataW-1:0] ore,
                           input logic signed [DataW-1:0] oim,
                           input logic [StepW-1:0] sre,
                           input logic [StepW-1:0] sim,
                           input logic [LimitW-1:0] lim);
    wait_drained();
    post_cfg(mep_pkg::CFG_ORIGIN_REAL, ore);
    post_cfg(mep_pkg::CFG_ORIGIN_IMAG, oim);
    post_cfg(mep_pkg::CFG_STEP_REAL, {1'($urandom), sre});
    post_cfg(mep_pkg::CFG_STEP_IMAG, {1'($urandom), sim});
    post_cfg(mep_pkg::CFG_ITER_LIMIT, {16'($urandom), lim});
    wait_drained();
  endtask

  // Pixel request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      pix_if.valid  <= 1'b0;
      pix_if.column <= '0;
      pix_if.row    <= '0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        expected_px_q.push_back(predict_escape(pix_if.column, pix_if.row));
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (pixel_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pixel_req_t p;
          p = pixel_req_q.pop_front();
          pix_if.valid  <= 1'b1;
          pix_if.column <= p.column;
          pix_if.row    <= p.row;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver; apply each accepted write to the local copy
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cfg_if.valid <= 1'b0;
      cfg_if.index <= '0;
      cfg_if.data  <= '0;
      m_origin_re  = mep_pkg::OriginRealReset;
      m_origin_im  = mep_pkg::OriginImagReset;
      m_step_re    = mep_pkg::StepRealReset;
      m_step_im    = mep_pkg::StepImagReset;
      m_limit      = mep_pkg::IterLimitReset;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          mep_pkg::CFG_ORIGIN_REAL: m_origin_re = cfg_if.data;
          mep_pkg::CFG_ORIGIN_IMAG: m_origin_im = cfg_if.data;
          mep_pkg::CFG_STEP_REAL:   m_step_re   = cfg_if.data[StepW-1:0];
          mep_pkg::CFG_STEP_IMAG:   m_step_im   = cfg_if.data[StepW-1:0];
          mep_pkg::CFG_ITER_LIMIT:  m_limit     = cfg_if.data[LimitW-1:0];
          default: ;
        endcase
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (cfg_write_q.size() != 0) begin
          cfg_write_t w;
          w = cfg_write_q.pop_front();
          cfg_if.valid <= 1'b1;
          cfg_if.index <= w.index;
          cfg_if.data  <= w.data;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_px_q.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d count %0d",
                                 res_if.pixel_value, res_if.iteration_count));
        end else begin
          pixel_res_t want;
          want = expected_px_q.pop_front();
          if (res_if.pixel_value !== want.pixel_value ||
              res_if.iteration_count !== want.iteration_count) begin
            note_failure($sformatf("result: expected value %0d count %0d, got value %0d count %0d",
                                   want.pixel_value, want.iteration_count,
                                   res_if.pixel_value, res_if.iteration_count));
          end
        end
      end
      res_if.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run after a long stretch with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                ore, oim;
    logic [StepW-1:0]  sre, sim;
    logic [LimitW-1:0] lim;
    pix_if.valid   = 1'b0;
    pix_if.column  = '0;
    pix_if.row     = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rx_hold        = 1'b0;
    quiet_cycles   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset view: corner, near the origin (bounded), far corner, top edge
    post_pixel(0, 0);
    post_pixel(427, 240);
    post_pixel(4095, 4095);
    post_pixel(320, 0);

    // Limits of zero and one stop before the first step; a limit of two allows one step
    load_view(mep_pkg::OriginRealReset, mep_pkg::OriginImagReset,
              mep_pkg::StepRealReset, mep_pkg::StepImagReset, 16'd0);
    post_pixel(427, 240);
    load_view(mep_pkg::OriginRealReset, mep_pkg::OriginImagReset,
              mep_pkg::StepRealReset, mep_pkg::StepImagReset, 16'd1);
    post_pixel(0, 0);
    load_view(mep_pkg::OriginRealReset, mep_pkg::OriginImagReset,
              mep_pkg::StepRealReset, mep_pkg::StepImagReset, 16'd2);
    post_pixel(427, 240);
    post_pixel(4095, 0);

    // Writes to unused indexes must leave the registers alone
    wait_drained();
    for (int k = CfgIdxFirstUnused; k < (1 << CfgIdxW); k++) begin
      post_cfg(CfgIdxW'(k), $urandom);
    end
    wait_drained();
    post_pixel(427, 240);

    // Point c pinned at the 32-bit extremes
    load_view(32'sh7fffffff, 32'sh80000000, 31'h7fffffff, 31'h7fffffff, 16'd8);
    post_pixel(0, 0);
    post_pixel(4095, 4095);
    post_pixel(1, 0);
    post_pixel(0, 1);
    load_view(32'sh80000000, 32'sh7fffffff, '0, '0, 16'd8);
    post_pixel(4095, 4095);
    post_pixel(0, 0);

    // c in range but large enough that the squares clamp
    load_view(32'sd1073741824, -32'sd1073741824, '0, '0, 16'd5);
    post_pixel(0, 0);

    // Highest limit: bounded at c = 0, and a column far outside
    load_view('0, '0, 31'd1 << 20, '0, 16'hffff);
    post_pixel(0, 0);
    post_pixel(4095, 0);

    // Hold off results while requests keep coming, so the core backs up
    load_view(-32'sd134217728, 32'sd83886080, 31'd3145728, 31'd2621440, 16'd6);
    for (int i = 0; i < 12; i++) begin
      post_pixel($urandom_range(63), $urandom_range(63));
    end
    rx_hold = 1'b1;
    repeat (HoldCycles) @(negedge clk);
    rx_hold = 1'b0;

    for (int p = 0; p < RandomPhases; p++) begin
      case (p % 3)
        0: begin
          // full set over a 64 x 64 grid
          ore = -134217728;
          oim = 83886080;
          sre = 31'd3145728;
          sim = 31'd2621440;
        end
        1: begin
          // zoom near the boundary around -0.75 + 0.1i
          ore = -50331648 + int'($urandom_range(1 << 23)) - (1 << 22);
          oim = 6710886 + int'($urandom_range(1 << 23)) - (1 << 22);
          sre = StepW'($urandom_range(1, 1 << 16));
          sim = StepW'($urandom_range(1, 1 << 16));
        end
        default: begin
          ore = $urandom;
          oim = $urandom;
          sre = StepW'($urandom);
          sim = StepW'($urandom);
        end
      endcase
      lim = (p == 3) ? mep_pkg::IterLimitReset : LimitW'($urandom_range(2, 100));
      load_view(ore, oim, sre, sim, lim);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        post_pixel(($urandom_range(99) < 80) ? $urandom_range(63) : $urandom_range(4095),
                   ($urandom_range(99) < 80) ? $urandom_range(63) : $urandom_range(4095));
      end
    end

    wait_drained();
    repeat (TailCycles) @(negedge clk);
    if (mismatches == 0 && expected_px_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
